// ===== hdl/modular_exponentiation_top_macros.svh =====
// Assertion macros for the modular exponentiation block.
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define MEXP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define MEXP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MEXP_ASSERT_IMP(lbl, ante, cons, msg)
`define MEXP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/mexp_pkg.sv =====
`timescale 1ns / 1ps

package mexp_pkg;

	localparam int MOD_W = 32;
	localparam int EXP_W = 63;

	typedef struct packed {
		logic [MOD_W-1:0] base_value;
		logic [EXP_W-1:0] exponent_value;
		logic [MOD_W-1:0] modulus_value;
	} mexp_in_t;

	typedef struct packed {
		logic [MOD_W-1:0] power_result;
		logic             bad_modulus;
	} mexp_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_LAUNCH,
		ST_STEP,
		ST_DONE
	} mexp_state_t;

endpackage

// ===== hdl/modular_exponentiation_top.sv =====
// Modular exponentiation, base ** exponent mod modulus, by right-to-left
// square-and-multiply. Raise start with the operands while busy is low; the
// result appears on result for exactly one cycle with done high and cannot be
// held off, so the receiver must take it then. A modulus of zero returns zero
// with bad_modulus set, a modulus of one returns zero; both give the result
// beat in the cycle right after start. Otherwise the base is first reduced,
// then the exponent bits up to the highest set one are taken in turn: two
// bit-serial double-and-add multipliers (multiply and square) run in lockstep,
// spending one add-and-reduce per cycle, two per modulus bit.
`timescale 1ns / 1ps
`include "modular_exponentiation_top_macros.svh"

module modular_exponentiation_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mexp_pkg::mexp_in_t  operands,
	output logic                done,
	output mexp_pkg::mexp_out_t result
);

	localparam int W = mexp_pkg::MOD_W;
	localparam int E = mexp_pkg::EXP_W;

	mexp_pkg::mexp_state_t state_q, state_d;

	logic [W-1:0] acc_q;
	logic [W-1:0] base_q;
	logic [W-1:0] mod_q;
	logic [E-1:0] exp_q;
	logic         bad_q;

	logic         accept;
	logic         mod_small;
	logic         go_a;
	logic         go_b;
	logic [W-1:0] a_x;
	logic [W-1:0] a_y;
	logic [W-1:0] a_m;
	logic         a_done;
	logic         b_done;
	logic [W-1:0] a_prod;
	logic [W-1:0] b_prod;

	assign accept    = start && !busy;
	assign mod_small = (operands.modulus_value[W-1:1] == '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mexp_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = mod_small ? mexp_pkg::ST_DONE : mexp_pkg::ST_REDUCE;
				end
			end
			mexp_pkg::ST_REDUCE: begin
				if (a_done) begin
					state_d = (exp_q == '0) ? mexp_pkg::ST_DONE : mexp_pkg::ST_LAUNCH;
				end
			end
			mexp_pkg::ST_LAUNCH: begin
				state_d = mexp_pkg::ST_STEP;
			end
			mexp_pkg::ST_STEP: begin
				if (a_done) begin
					state_d = (exp_q[E-1:1] == '0) ? mexp_pkg::ST_DONE
						: mexp_pkg::ST_LAUNCH;
				end
			end
			mexp_pkg::ST_DONE: begin
				state_d = mexp_pkg::ST_IDLE;
			end
			default: begin
				state_d = mexp_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy = (state_q != mexp_pkg::ST_IDLE);
		done = (state_q == mexp_pkg::ST_DONE);
		go_a = (accept && !mod_small) || (state_q == mexp_pkg::ST_LAUNCH);
		go_b = (state_q == mexp_pkg::ST_LAUNCH);
		if (state_q == mexp_pkg::ST_IDLE) begin
			a_x = W'(1);
			a_y = operands.base_value;
			a_m = operands.modulus_value;
		end else begin
			a_x = acc_q;
			a_y = base_q;
			a_m = mod_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mexp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			exp_q <= operands.exponent_value;
			mod_q <= operands.modulus_value;
			bad_q <= (operands.modulus_value == '0);
			acc_q <= mod_small ? '0 : W'(1);
		end else if (state_q == mexp_pkg::ST_REDUCE && a_done) begin
			base_q <= a_prod;
		end else if (state_q == mexp_pkg::ST_STEP && a_done) begin
			if (exp_q[0]) begin
				acc_q <= a_prod;
			end
			base_q <= b_prod;
			exp_q  <= {1'b0, exp_q[E-1:1]};
		end
	end

	mexp_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go_a),
		.x      (a_x),
		.y      (a_y),
		.m      (a_m),
		.done   (a_done),
		.prod   (a_prod)
	);

	mexp_mulmod u_sqr (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go_b),
		.x      (base_q),
		.y      (base_q),
		.m      (mod_q),
		.done   (b_done),
		.prod   (b_prod)
	);

	assign result.power_result = acc_q;
	assign result.bad_modulus  = bad_q;

	`MEXP_ASSERT_NXT(a_done_single, done, !done, "result beat longer than one cycle")
	`MEXP_ASSERT_IMP(a_lockstep, (state_q == mexp_pkg::ST_STEP) && a_done, b_done,
		"multipliers out of step")
	`MEXP_ASSERT_NXT(a_zero_mod, accept && (operands.modulus_value == '0),
		done && result.bad_modulus, "zero modulus not flagged")
	`MEXP_ASSERT_IMP(a_in_range, done && !result.bad_modulus,
		result.power_result < mod_q, "result not below modulus")

endmodule

// ===== hdl/mexp_mulmod.sv =====
`timescale 1ns / 1ps

module mexp_mulmod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [mexp_pkg::MOD_W-1:0] x,
	input  logic [mexp_pkg::MOD_W-1:0] y,
	input  logic [mexp_pkg::MOD_W-1:0] m,
	output logic                      done,
	output logic [mexp_pkg::MOD_W-1:0] prod
);

	localparam int W     = mexp_pkg::MOD_W;
	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     acc_q;
	logic [W-1:0]     x_q;
	logic [W-1:0]     y_q;
	logic [W-1:0]     m_q;
	logic [CNT_W-1:0] cnt_q;
	logic             phase_q;
	logic             run_q;
	logic             done_q;

	logic [W:0]       sum;
	logic [W+1:0]     diff;
	logic [W-1:0]     red;

	// add_mod: phase 0 doubles, phase 1 adds x
	always_comb begin
		sum  = {1'b0, acc_q} + {1'b0, (phase_q ? x_q : acc_q)};
		diff = {1'b0, sum} - {2'b00, m_q};
		red  = diff[W+1] ? sum[W-1:0] : diff[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q   <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= CNT_W'(W);
			end else if (run_q) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						run_q  <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
			m_q   <= m;
		end else if (run_q) begin
			if (!phase_q) begin
				acc_q <= red;
			end else begin
				if (y_q[W-1]) begin
					acc_q <= red;
				end
				y_q <= {y_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule
